/* hdl/mhpq_pkg.sv */
// package for the max-heap priority queue: beat types, opcode and status codes
// and sizing constants; depends on nothing
`default_nettype none

package mhpq_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 5;

  localparam logic signed [KEY_W-1:0] EMPTY_TOP = -32'sd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] top_value;
    logic [COUNT_W-1:0]      element_count;
  } out_t;

  // command broadcast from the top level to every cell of the chain
  typedef struct packed {
    logic                    shift_in;
    logic                    shift_out;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/mhpq_cell.sv */
// one slot of the sorted chain: holds a key and trades it with its neighbours
// depends on mhpq_pkg
`default_nettype none

module mhpq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                              clk_i,
  input  wire mhpq_pkg::cmd_t                    cmd_i,
  input  wire logic [CNT_W-1:0]                  count_i,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] left_q_i,
  input  wire logic                              left_ge_i,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] right_q_i,
  output logic signed [mhpq_pkg::KEY_W-1:0]      q_o,
  output logic signed [mhpq_pkg::KEY_W-1:0]      d_o,
  output logic                                   ge_o
);

  logic signed [mhpq_pkg::KEY_W-1:0] key_q;
  logic signed [mhpq_pkg::KEY_W-1:0] key_d;

  // slot is held and its key beats or ties the incoming one
  assign ge_o = (count_i > CNT_W'(IDX)) && (key_q >= cmd_i.key);

  always_comb begin
    key_d = key_q;
    if (cmd_i.shift_in) begin
      if (ge_o) key_d = key_q;
      else if (left_ge_i) key_d = cmd_i.key;
      else key_d = left_q_i;
    end else if (cmd_i.shift_out) begin
      key_d = right_q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign q_o = key_q;
  assign d_o = key_d;

endmodule

`default_nettype wire

/* hdl/max_heap_priority_queue.sv */
// top level of the max-heap priority queue: handshake, fill count and cell chain
// depends on mhpq_pkg and mhpq_cell
`default_nettype none

// max priority queue of signed 32-bit keys with insert, delete-max and peek.
// keys sit in a chain of CAPACITY cells kept in descending order, so the
// largest key is always in the first cell. an insert is broadcast to every
// cell at once: each cell keeps its key, takes the new key, or takes its left
// neighbour's key, which opens a gap at the right place. a delete-max shifts
// the whole chain one cell towards the head. each result beat is loaded into
// the output register on acceptance and shows up in the cycle after it, and a
// new beat is taken in the same cycle as the waiting result is taken, so the
// queue sustains one beat per cycle as long as the receiver takes every result
// as it appears (no stall on the output). each result carries a status
// (done, full so the insert was dropped, or empty), the largest key after
// the operation (-1 when empty) and the count of keys held. opcode 3 acts as
// a peek. key storage is not reset; only the fill count and the output
// valid flag are.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mhpq_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mhpq_pkg::out_t      out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // fill count and output register
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  mhpq_pkg::out_t   out_q, out_d;

  logic             in_fire;
  logic             is_full, is_empty;
  mhpq_pkg::cmd_t   cmd;
  logic [mhpq_pkg::STATUS_W-1:0] status;

  // chain taps
  logic signed [mhpq_pkg::KEY_W-1:0] cell_q [CAPACITY];
  logic signed [mhpq_pkg::KEY_W-1:0] cell_d [CAPACITY];
  logic                              cell_ge [CAPACITY];

  // a new beat goes in whenever the output register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // decode the opcode into a chain command and a status
  always_comb begin
    cmd.shift_in  = 1'b0;
    cmd.shift_out = 1'b0;
    cmd.key       = in_data_i.key;
    status        = mhpq_pkg::ST_DONE;
    count_d       = count_q;
    unique case (in_data_i.opcode)
      mhpq_pkg::OP_INSERT: begin
        if (is_full) begin
          status = mhpq_pkg::ST_FULL;
        end else begin
          cmd.shift_in = in_fire;
          if (in_fire) count_d = count_q + CNT_W'(1);
        end
      end
      mhpq_pkg::OP_DELETE: begin
        if (is_empty) begin
          status = mhpq_pkg::ST_EMPTY;
        end else begin
          cmd.shift_out = in_fire;
          if (in_fire) count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        // peek, and the unused code which behaves as one
        if (is_empty) status = mhpq_pkg::ST_EMPTY;
      end
    endcase
  end

  // row of cells; head takes the new key when nothing ahead of it wins,
  // tail refills from itself on a shift, which is beyond the count anyway
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [mhpq_pkg::KEY_W-1:0] left_q;
    logic                              left_ge;
    logic signed [mhpq_pkg::KEY_W-1:0] right_q;

    if (i == 0) begin : g_head
      assign left_q  = cell_q[i];
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left_q  = cell_q[i-1];
      assign left_ge = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_q = cell_q[i];
    end else begin : g_next
      assign right_q = cell_q[i+1];
    end

    mhpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (count_q),
      .left_q_i  (left_q),
      .left_ge_i (left_ge),
      .right_q_i (right_q),
      .q_o       (cell_q[i]),
      .d_o       (cell_d[i]),
      .ge_o      (cell_ge[i])
    );
  end

  // result beat built from the state after the operation
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_fire) begin
      out_valid_d             = 1'b1;
      out_d.status            = status;
      out_d.top_value         = (count_d == '0) ? mhpq_pkg::EMPTY_TOP : cell_d[0];
      out_d.element_count     = mhpq_pkg::COUNT_W'(count_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/mhpq_checker.sv */
// port-level checks for the max-heap priority queue, bound to the top level
// depends on mhpq_pkg and max_heap_priority_queue
`default_nettype none

module mhpq_checker #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire mhpq_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire mhpq_pkg::out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // every accepted beat gives a result on the next clock
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // an empty queue reports -1 as its top
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.element_count == '0 |-> out_data_o.top_value == -32'sd1)
    else $error("empty queue with a top other than -1");

  // a dropped insert only happens at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == mhpq_pkg::ST_FULL
      |-> out_data_o.element_count == mhpq_pkg::COUNT_W'(CAPACITY))
    else $error("full status below capacity");

  // empty status only with nothing held
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == mhpq_pkg::ST_EMPTY
      |-> out_data_o.element_count == '0)
    else $error("empty status with keys held");

endmodule

bind max_heap_priority_queue mhpq_checker #(
  .CAPACITY (CAPACITY)
) u_mhpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* verif/mhpq_checker.sv */
// result checker for the max-heap priority queue: watches both channels, keeps its own heap
// and compares every result beat against the oldest awaited result
// depends on mhpq_pkg
module mhpq_tb_checker
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   awaited_o,
  output int   results_seen_o,
  output int   full_drops_o,
  output int   empty_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned             heap_fill;
  out_t                    awaited_results [$];
  out_t                    oldest;

  initial begin
    fail_count_o   = 0;
    awaited_o      = 0;
    results_seen_o = 0;
    full_drops_o   = 0;
    empty_hits_o   = 0;
    heap_fill      = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // applies one operation to the shadow heap and returns the result it yields
  function automatic out_t apply_heap_op(input in_t beat);
    out_t                    res;
    int unsigned             pos;
    int unsigned             parent;
    int unsigned             best;
    int unsigned             lc;
    int unsigned             rc;
    logic signed [KEY_W-1:0] tmp;
    res.status = ST_DONE;
    case (beat.opcode)
      OP_INSERT: begin
        if (heap_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_keys[heap_fill] = beat.key;
          pos = heap_fill;
          heap_fill++;
          // sift up while the parent is strictly smaller
          while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_keys[parent] < heap_keys[pos])) break;
            tmp = heap_keys[parent];
            heap_keys[parent] = heap_keys[pos];
            heap_keys[pos] = tmp;
            pos = parent;
          end
        end
      end
      OP_DELETE: begin
        if (heap_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          heap_fill--;
          if (heap_fill > 0) begin
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            // sift down, left child wins unless the right is strictly larger
            forever begin
              best = pos;
              lc = 2 * pos + 1;
              rc = lc + 1;
              if (lc < heap_fill && heap_keys[lc] > heap_keys[best]) best = lc;
              if (rc < heap_fill && heap_keys[rc] > heap_keys[best]) best = rc;
              if (best == pos) break;
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[best];
              heap_keys[best] = tmp;
              pos = best;
            end
          end
        end
      end
      default: begin
        // peek and the spare opcode
        if (heap_fill == 0) res.status = ST_EMPTY;
      end
    endcase
    res.top_value     = (heap_fill == 0) ? EMPTY_TOP : heap_keys[0];
    res.element_count = COUNT_W'(heap_fill);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      heap_fill = 0;
      awaited_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) awaited_results.push_back(apply_heap_op(in_data_i));
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited, top_value",
                          $signed(out_data_i.top_value), 0);
        end else begin
          oldest = awaited_results.pop_front();
          if (oldest.status == ST_FULL) full_drops_o++;
          if (oldest.status == ST_EMPTY) empty_hits_o++;
          if (out_data_i.status !== oldest.status)
            report_mismatch("status", out_data_i.status, oldest.status);
          if (out_data_i.top_value !== oldest.top_value)
            report_mismatch("top_value", $signed(out_data_i.top_value),
                            $signed(oldest.top_value));
          if (out_data_i.element_count !== oldest.element_count)
            report_mismatch("element_count", out_data_i.element_count,
                            oldest.element_count);
        end
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

/* verif/tb_max_heap_priority_queue.sv */
// stimulus and verdict for the max-heap priority queue
// depends on mhpq_pkg, max_heap_priority_queue and mhpq_tb_checker
module tb_max_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int RANDOM_BEATS = 600;
  localparam int LIMIT_CYCLES = 200000;
  // receiver hold-off: starts once this many beats went in, lasts this many cycles
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 60;
  // no idling on either side while the beat count is inside this window
  localparam int CALM_FROM    = 260;
  localparam int CALM_TO      = 360;
  // sender waits for every awaited result at this random beat
  localparam int PAUSE_AT     = 420;
  // opcode 3 has no name in the package and behaves as a peek
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int awaited;
  int results_seen;
  int full_drops;
  int empty_hits;

  int beats_sent;
  int inserts_sent;
  int deletes_sent;
  int peeks_sent;
  int cycles;
  bit held_off;

  // both sides run flat out inside the calm window
  wire calm = (beats_sent >= CALM_FROM) && (beats_sent < CALM_TO);

  max_heap_priority_queue dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  mhpq_tb_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .awaited_o      (awaited),
    .results_seen_o (results_seen),
    .full_drops_o   (full_drops),
    .empty_hits_o   (empty_hits)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: generous bound on a correct run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results awaited", cycles, awaited);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off so the output register
  // stays occupied and the queue stalls its input
  initial begin
    out_ready = 1'b0;
    held_off  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && beats_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // one input beat, with an occasional one-cycle gap ahead of it
  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic signed [KEY_W-1:0] key);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, key: key};
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    case (op)
      OP_INSERT: inserts_sent++;
      OP_DELETE: deletes_sent++;
      default:   peeks_sent++;
    endcase
  endtask

  // keys: a narrow range for ties, some extremes, the rest full width
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return $signed(32'($urandom_range(15))) - 32'sd8;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // opcode mix leans towards filling or draining, or stays even, so both ends get hit often
  function automatic logic [OPCODE_W-1:0] pick_opcode(input mix_e mix);
    int roll;
    int ins_pct;
    int del_pct;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin ins_pct = 70; del_pct = 20; end
      MIX_DRAIN: begin ins_pct = 20; del_pct = 70; end
      default:   begin ins_pct = 45; del_pct = 45; end
    endcase
    if (roll < ins_pct) return OP_INSERT;
    if (roll < ins_pct + del_pct) return OP_DELETE;
    return ($urandom_range(1) == 0) ? OP_PEEK : OP_SPARE;
  endfunction

  initial begin
    int   i;
    mix_e mix;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode on an empty heap
    send_beat(OP_PEEK, pick_key());
    send_beat(OP_DELETE, pick_key());
    send_beat(OP_SPARE, pick_key());
    // key extremes
    send_beat(OP_INSERT, 32'sh7fff_ffff);
    send_beat(OP_INSERT, 32'sh8000_0000);
    send_beat(OP_INSERT, 32'sd0);
    send_beat(OP_INSERT, -32'sd1);
    // peek on a non-empty heap, spare opcode too, then one delete
    send_beat(OP_PEEK, pick_key());
    send_beat(OP_SPARE, pick_key());
    send_beat(OP_DELETE, pick_key());
    // fill to capacity with ties among the keys
    for (i = 0; i < 13; i++) send_beat(OP_INSERT, $signed(32'(i % 5)) - 32'sd2);
    // insert into a full heap is dropped
    send_beat(OP_INSERT, 32'sh7fff_ffff);
    send_beat(OP_PEEK, pick_key());

    // random part, mix is redrawn every 32 beats
    mix = MIX_DRAIN;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 32 == 0) mix = mix_e'($urandom_range(2));
      if (i == PAUSE_AT) begin
        // drain the pipe completely before carrying on
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
      end
      send_beat(pick_opcode(mix), pick_key());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d beats: %0d inserts, %0d deletes, %0d peeks",
             beats_sent, inserts_sent, deletes_sent, peeks_sent);
    $display("receiver held off %0d cycles; checked %0d results, %0d dropped inserts, %0d empty",
             HOLD_CYCLES, results_seen, full_drops, empty_hits);
    if (fail_count == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mhpq_pkg.sv
hdl/mhpq_cell.sv
hdl/max_heap_priority_queue.sv
hdl/mhpq_checker.sv
verif/mhpq_checker.sv
verif/tb_max_heap_priority_queue.sv
